FILE: sv/assert_macros.svh
// assertion macros shared by the base64 codec rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// antecedent at one edge forces the consequent at the next edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/b64_pkg.sv
// shared types and constants of the base64 codec
// no dependencies; imported by front, queue, back and top level
`default_nettype none

package b64_pkg;

    // mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // one group worth of results, handed from front to back
    typedef struct packed {
        logic [31:0] payload;    // result k in bits [8k+7:8k]
        logic [1:0]  nres_m1;    // number of results minus one
        logic        data_valid; // 0 marks an empty end marker
        logic        last;       // group closes the message
        logic        stopped;    // decode input was cut
    } b64_job_t;

endpackage

`default_nettype wire

FILE: sv/b64_front.sv
// front end: takes requests, gathers groups, builds result jobs
// depends on b64_pkg; pushes jobs into b64_queue
`default_nettype none
`include "assert_macros.svh"

module b64_front
    import b64_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic [7:0] in_byte,
    input  wire logic     in_last,
    input  wire logic     q_full,
    output logic          push,
    output b64_job_t      push_job
);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // sextet to alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] r;
        if (s < 6'd26) begin
            r = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            r = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            r = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    // character to sextet, bit 6 flags a character outside the alphabet
    function automatic logic [6:0] b64_sextet(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b0, 6'd63};
        end else begin
            r = 7'h40;
        end
        return r;
    endfunction

    logic        mode_reg, mode_next;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  count_reg, count_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [23:0] enc_acc, dec_acc, dec_shift;
    logic [2:0]  enc_n1, dec_n1;
    logic [6:0]  sext;
    logic        sext_ok;
    logic        halted_new;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // encode: place the byte into the group
    always_comb begin
        unique case (count_reg)
            2'd0: enc_acc = bits_reg | {in_byte, 16'h0000};
            2'd1: enc_acc = bits_reg | {8'h00, in_byte, 8'h00};
            2'd2: enc_acc = bits_reg | {16'h0000, in_byte};
            2'd3: enc_acc = bits_reg;
        endcase
    end
    assign enc_n1 = {1'b0, count_reg} + 3'd1;

    // decode: map the character and place its sextet
    assign sext       = b64_sextet(in_byte);
    assign sext_ok    = !halted_reg && !sext[6];
    assign halted_new = halted_reg || sext[6];
    always_comb begin
        unique case (count_reg)
            2'd0: dec_shift = {sext[5:0], 18'h0};
            2'd1: dec_shift = {6'h0, sext[5:0], 12'h0};
            2'd2: dec_shift = {12'h0, sext[5:0], 6'h0};
            2'd3: dec_shift = {18'h0, sext[5:0]};
        endcase
    end
    assign dec_acc = sext_ok ? (bits_reg | dec_shift) : bits_reg;
    assign dec_n1  = sext_ok ? ({1'b0, count_reg} + 3'd1) : {1'b0, count_reg};

    // job building and group state update
    always_comb begin
        mode_next   = mode_reg;
        bits_next   = bits_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_job    = '0;

        priority if (cfg_wr_en) begin
            mode_next   = cfg_wr_data;
            bits_next   = '0;
            count_next  = '0;
            halted_next = 1'b0;
        end else if (accept && mode_reg == MODE_ENCODE) begin
            push_job.payload = {
                (enc_n1 >= 3'd3) ? b64_char(enc_acc[5:0])   : PAD_CHAR,
                (enc_n1 >= 3'd2) ? b64_char(enc_acc[11:6])  : PAD_CHAR,
                b64_char(enc_acc[17:12]),
                b64_char(enc_acc[23:18])
            };
            push_job.nres_m1    = 2'd3;
            push_job.data_valid = 1'b1;
            push_job.last       = in_last;
            push_job.stopped    = 1'b0;
            if (enc_n1 == 3'd3 || in_last) begin
                push       = 1'b1;
                bits_next  = '0;
                count_next = '0;
            end else begin
                bits_next  = enc_acc;
                count_next = enc_n1[1:0];
            end
        end else if (accept) begin
            push_job.payload    = {8'h00, dec_acc[7:0], dec_acc[15:8], dec_acc[23:16]};
            push_job.data_valid = 1'b1;
            push_job.last       = in_last;
            push_job.stopped    = halted_new;
            halted_next         = halted_new;
            if (dec_n1 == 3'd4) begin
                // full group of four sextets gives three bytes
                push                = 1'b1;
                push_job.nres_m1    = 2'd2;
                bits_next           = '0;
                count_next          = '0;
            end else begin
                bits_next  = dec_acc;
                count_next = dec_n1[1:0];
                if (in_last) begin
                    push = 1'b1;
                    if (dec_n1 >= 3'd2) begin
                        push_job.nres_m1 = 2'(dec_n1 - 3'd2);
                    end else begin
                        // nothing to flush: empty end marker
                        push_job.payload    = '0;
                        push_job.nres_m1    = 2'd0;
                        push_job.data_valid = 1'b0;
                    end
                end
            end
            if (in_last) begin
                bits_next   = '0;
                count_next  = '0;
                halted_next = 1'b0;
            end
        end
    end

    // group state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCODE;
            bits_reg   <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            bits_reg   <= bits_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    // checks
    `ASSERT_NEXT(a_last_clears, aclk, aresetn, accept && in_last && !cfg_wr_en,
        count_reg == 2'd0 && !halted_reg && bits_reg == 24'h0, "group not cleared after last")
    `ASSERT_ALWAYS(a_halt_decode_only, aclk, aresetn, mode_reg == MODE_DECODE || !halted_reg,
        "halted set in encode mode")

endmodule

`default_nettype wire

FILE: sv/b64_queue.sv
// short job queue between front and back, flip-flop storage
// depends on b64_pkg for the job type
`default_nettype none
`include "assert_macros.svh"

module b64_queue
    import b64_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire b64_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          nonempty,
    output b64_job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign head_job = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // checks
    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, !(push && full), "push into full queue")
    `ASSERT_ALWAYS(a_no_underflow, aclk, aresetn, !(pop && !nonempty), "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/b64_back.sv
// back end: serializes queued jobs into single results with an output register
// depends on b64_pkg for the job type
`default_nettype none
`include "assert_macros.svh"

module b64_back
    import b64_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     q_nonempty,
    input  wire b64_job_t head_job,
    output logic          pop,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [7:0]    out_byte,
    output logic          out_valid,
    output logic          out_last,
    output logic          out_stopped
);

    logic [1:0] idx_reg, idx_next;
    logic       tvalid_reg, tvalid_next;
    logic [7:0] byte_reg, byte_next;
    logic       valid_reg, last_reg, stopped_reg;
    logic       out_free, load, job_done;

    assign out_free = !tvalid_reg || m_tready;
    assign load     = q_nonempty && out_free;
    assign job_done = idx_reg == head_job.nres_m1;
    assign pop      = load && job_done;

    // pick the current result of the head job
    always_comb begin
        unique case (idx_reg)
            2'd0: byte_next = head_job.payload[7:0];
            2'd1: byte_next = head_job.payload[15:8];
            2'd2: byte_next = head_job.payload[23:16];
            2'd3: byte_next = head_job.payload[31:24];
        endcase
    end

    // result index and output valid
    always_comb begin
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg;
        if (load) begin
            idx_next    = job_done ? 2'd0 : idx_reg + 2'd1;
            tvalid_next = 1'b1;
        end else if (m_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg    <= byte_next;
            valid_reg   <= head_job.data_valid;
            last_reg    <= head_job.last && job_done;
            stopped_reg <= head_job.stopped;
        end
    end

    assign m_tvalid    = tvalid_reg;
    assign out_byte    = byte_reg;
    assign out_valid   = valid_reg;
    assign out_last    = last_reg;
    assign out_stopped = stopped_reg;

    // checks
    `ASSERT_ALWAYS(a_idx_in_job, aclk, aresetn, !q_nonempty || idx_reg <= head_job.nres_m1,
        "result index past end of job")
    `ASSERT_ALWAYS(a_idx_idle_zero, aclk, aresetn, q_nonempty || idx_reg == 2'd0,
        "result index not reset between jobs")

endmodule

`default_nettype wire

FILE: sv/base64_codec_core.sv
// base64 codec top level: front end, job queue, back end; uses b64_pkg
// path: each pushed job passes through the queue and then the back end output register to m_
// throughput: one input per cycle while the queue has room; one result per cycle while
// m_tready is high, set by the back end serializer; four results per three encode inputs
// reset: synchronous active-low aresetn clears mode to encode, group state, queue and output valid
`default_nettype none

module base64_codec_core
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2  // jobs between front and back, 2 to 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,   // mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic [1:0]      m_tuser,       // [0] out_valid, [1] stopped
    output logic            m_tlast
);

    logic     q_full, q_nonempty, push, pop;
    b64_job_t push_job, head_job;
    logic     out_valid, out_stopped;

    b64_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .nonempty (q_nonempty),
        .head_job (head_job)
    );

    b64_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_nonempty  (q_nonempty),
        .head_job    (head_job),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (m_tdata),
        .out_valid   (out_valid),
        .out_last    (m_tlast),
        .out_stopped (out_stopped)
    );

    assign m_tuser = {out_stopped, out_valid};

endmodule

`default_nettype wire
